// ===== hw/rtl/ssq_pkg.sv =====
// shared types and constants for the sorted stack priority queue
package ssq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned ValW  = 32;

  typedef enum logic [0:0] {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk       = 2'd0,
    StatPopEmpty = 2'd1,
    StatPushFull = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] popped_value;
    logic signed [ValW-1:0] top_value;
    logic [CntW-1:0]        count;
    logic                   empty_res;
    status_e                status;
  } out_t;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic                   push;
    logic                   pop;
    logic signed [ValW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_stack_priority_queue_unit.sv =====
// top level of the sorted stack priority queue: cell chain, fill count, result register
//
//   channel | direction | payload         | handshake
//   in      | input     | in_i  (in_t)    | in_valid_i / in_stall_o
//   out     | output    | out_o (out_t)   | out_valid_o / out_stall_i
//
// one beat per cycle unless the input stalls: a push or pop updates every
// cell of the chain when it is accepted; the result appears the cycle after.
// reset clears the fill count and the result valid; cell contents stay
// undefined until written. the input stalls only while a result waits on a
// stalled output.
module sorted_stack_priority_queue_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssq_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssq_pkg::out_t  out_o
);

  localparam int unsigned N = ssq_pkg::Depth;

  logic [ssq_pkg::CntW-1:0] count_q, count_d;
  logic                     out_valid_q;
  ssq_pkg::out_t            out_q, out_d;
  ssq_pkg::cell_ctrl_t      ctrl;
  logic                     accept, full, empty;

  logic signed [ssq_pkg::ValW-1:0] entry   [N];
  logic signed [ssq_pkg::ValW-1:0] entry_d [N];
  logic                            mv      [N];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == ssq_pkg::CntW'(N));
  assign empty      = (count_q == '0);

  assign ctrl.push  = accept && (in_i.cmd == ssq_pkg::CmdPush) && !full;
  assign ctrl.pop   = accept && (in_i.cmd == ssq_pkg::CmdPop) && !empty;
  assign ctrl.value = in_i.value;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic occ;
    assign occ = (count_q > ssq_pkg::CntW'(i));
    if (i == 0) begin : g_first
      if (N == 1) begin : g_only
        ssq_cell u_cell (
          .clk_i        (clk_i),
          .ctrl_i       (ctrl),
          .occ_i        (occ),
          .prev_entry_i (ctrl.value),
          .prev_mv_i    (1'b0),
          .next_entry_i (entry[i]),
          .entry_o      (entry[i]),
          .entry_d_o    (entry_d[i]),
          .mv_o         (mv[i])
        );
      end else begin : g_head
        ssq_cell u_cell (
          .clk_i        (clk_i),
          .ctrl_i       (ctrl),
          .occ_i        (occ),
          .prev_entry_i (ctrl.value),
          .prev_mv_i    (1'b0),
          .next_entry_i (entry[i+1]),
          .entry_o      (entry[i]),
          .entry_d_o    (entry_d[i]),
          .mv_o         (mv[i])
        );
      end
    end else if (i == N - 1) begin : g_last
      // the bottom slot refills from itself on pop
      ssq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occ_i        (occ),
        .prev_entry_i (entry[i-1]),
        .prev_mv_i    (mv[i-1]),
        .next_entry_i (entry[i]),
        .entry_o      (entry[i]),
        .entry_d_o    (entry_d[i]),
        .mv_o         (mv[i])
      );
    end else begin : g_mid
      ssq_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .occ_i        (occ),
        .prev_entry_i (entry[i-1]),
        .prev_mv_i    (mv[i-1]),
        .next_entry_i (entry[i+1]),
        .entry_o      (entry[i]),
        .entry_d_o    (entry_d[i]),
        .mv_o         (mv[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + ssq_pkg::CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - ssq_pkg::CntW'(1);
    end
  end

  always_comb begin
    out_d              = out_q;
    out_d.popped_value = ctrl.pop ? entry[0] : '0;
    out_d.top_value    = (count_d != '0) ? entry_d[0] : '0;
    out_d.count        = count_d;
    out_d.empty_res    = (count_d == '0);
    out_d.status       = ssq_pkg::StatOk;
    if (in_i.cmd == ssq_pkg::CmdPush && full) begin
      out_d.status = ssq_pkg::StatPushFull;
    end else if (in_i.cmd == ssq_pkg::CmdPop && empty) begin
      out_d.status = ssq_pkg::StatPopEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hw/rtl/ssq_cell.sv =====
// one slot of the sorted shift chain
module ssq_cell (
  input  logic                            clk_i,
  input  ssq_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            occ_i,
  input  logic signed [ssq_pkg::ValW-1:0] prev_entry_i,
  input  logic                            prev_mv_i,
  input  logic signed [ssq_pkg::ValW-1:0] next_entry_i,
  output logic signed [ssq_pkg::ValW-1:0] entry_o,
  output logic signed [ssq_pkg::ValW-1:0] entry_d_o,
  output logic                            mv_o
);

  logic signed [ssq_pkg::ValW-1:0] entry_q, entry_d;
  logic                            mv;

  // this slot is at or below the insertion point
  assign mv = !occ_i || (entry_q >= ctrl_i.value);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push && mv) begin
      entry_d = prev_mv_i ? prev_entry_i : ctrl_i.value;
    end else if (ctrl_i.pop) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;
  assign mv_o      = mv;

endmodule
